/* sv/ttceb_pkg.sv */
// Shared types, constants and the arctangent table of the emergency brake block.
// Used by the top, front, queue and back modules and by the testbench; depends on nothing.
package ttceb_pkg;

   localparam int MAX_BEAMS    = 2048;
   localparam int BEAM_W       = $clog2(MAX_BEAMS);
   localparam int HIT_W        = 11;
   localparam int CORDIC_STEPS = 16;
   localparam int ITER_W       = 5;
   localparam int CW           = 34;
   localparam int QDEPTH       = 4;
   localparam int QPTR_W       = $clog2(QDEPTH);

   localparam logic [CW-1:0] CORDIC_GAIN = CW'(652032874);

   localparam logic [2:0] CSR_START_ANGLE = 3'd0;
   localparam logic [2:0] CSR_ANGLE_STEP  = 3'd1;
   localparam logic [2:0] CSR_MIN_RANGE   = 3'd2;
   localparam logic [2:0] CSR_MAX_RANGE   = 3'd3;
   localparam logic [2:0] CSR_TTC_LIMIT   = 3'd4;
   localparam logic [2:0] CSR_HALF_WIDTH  = 3'd5;

   typedef struct packed {
      logic [31:0] start_angle;
      logic [23:0] angle_step;
      logic [15:0] min_range_mm;
      logic [15:0] max_range_mm;
      logic [15:0] ttc_limit_ms;
      logic [15:0] half_width_mm;
   } cfg_type;

   typedef struct packed {
      logic [15:0]        range_mm;
      logic signed [15:0] speed_mm_s;
      logic               scan_end;
      logic               in_window;
      logic [31:0]        angle;
      logic [BEAM_W-1:0]  index;
   } beam_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_ROT, ST_MUL, ST_MUL2, ST_CMP, ST_OUT
   } back_state_type;

   // Arctangent of 2^-i in units of 2^-32 turn.
   function automatic logic [CW-1:0] atan_turn(input logic [ITER_W-1:0] i);
      logic [CW-1:0] r;
      case (i)
         5'd0:  r = CW'(536870912);
         5'd1:  r = CW'(316933406);
         5'd2:  r = CW'(167458907);
         5'd3:  r = CW'(85004756);
         5'd4:  r = CW'(42667331);
         5'd5:  r = CW'(21354465);
         5'd6:  r = CW'(10679838);
         5'd7:  r = CW'(5340245);
         5'd8:  r = CW'(2670163);
         5'd9:  r = CW'(1335087);
         5'd10: r = CW'(667544);
         5'd11: r = CW'(333772);
         5'd12: r = CW'(166886);
         5'd13: r = CW'(83443);
         5'd14: r = CW'(41722);
         5'd15: r = CW'(20861);
         5'd16: r = CW'(10430);
         5'd17: r = CW'(5215);
         5'd18: r = CW'(2608);
         5'd19: r = CW'(1304);
         5'd20: r = CW'(652);
         5'd21: r = CW'(326);
         5'd22: r = CW'(163);
         5'd23: r = CW'(81);
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

/* sv/ttceb_req_if.sv */
// Beam channel interface: valid/ready handshake plus one lidar beam.
// Stands alone; no package needed.
interface ttceb_req_if;
   logic               valid;
   logic               ready;
   logic [15:0]        range_mm;
   logic               range_ok;
   logic signed [15:0] speed_mm_s;
   logic               scan_end;

   modport source (output valid, range_mm, range_ok, speed_mm_s, scan_end, input ready);
   modport sink   (input valid, range_mm, range_ok, speed_mm_s, scan_end, output ready);
endinterface

/* sv/ttceb_rsp_if.sv */
// Result channel interface: valid/ready handshake plus the per-scan verdict.
// Stands alone; no package needed.
interface ttceb_rsp_if;
   logic        valid;
   logic        ready;
   logic        brake;
   logic [10:0] hit_beam;

   modport source (output valid, brake, hit_beam, input ready);
   modport sink   (input valid, brake, hit_beam, output ready);
endinterface

/* sv/ttc_emergency_brake_top.sv */
// Top level of the time-to-collision emergency brake block.
// Depends on ttceb_pkg, both channel interfaces, and the front, queue and back modules.
//
// The block takes the lidar beams of one scan in order, one beam per req transaction, and
// answers with one rsp transaction on the beam marked scan_end: brake is set if any beam of
// the scan fell inside the corridor with a time to collision below ttc_limit_ms, and
// hit_beam gives the index of the first such beam. A front end accepts each beam, numbers
// it, checks the range window and forms its angle; a four-entry queue then hands it to the
// evaluation engine. The engine takes each beam from the queue in its idle state and
// passes over one that fails the window or follows a hit; a beam it evaluates goes through
// the iterative CORDIC rotation, which sets the rate, then ST_MUL, ST_MUL2 and the
// compare state. The scan_end beam then passes through ST_OUT, which loads the result
// register once rsp is free. Because of the queue the front end keeps taking beams until
// the queue is full while the engine works or a result waits on rsp. Configuration writes
// on the csr port take effect at once and belong between scans, with the block idle.
module ttc_emergency_brake_top (
   input  logic        clock,
   input  logic        reset,
   ttceb_req_if.sink   req,
   ttceb_rsp_if.source rsp,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   ttceb_pkg::cfg_type  cfg_ff, cfg_in;
   ttceb_pkg::beam_type push_data, pop_data;
   logic                push, pop, full, empty;

   // Register file: writes to an index past the list are dropped.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            ttceb_pkg::CSR_START_ANGLE: cfg_in.start_angle   = csr_wdata;
            ttceb_pkg::CSR_ANGLE_STEP:  cfg_in.angle_step    = csr_wdata[23:0];
            ttceb_pkg::CSR_MIN_RANGE:   cfg_in.min_range_mm  = csr_wdata[15:0];
            ttceb_pkg::CSR_MAX_RANGE:   cfg_in.max_range_mm  = csr_wdata[15:0];
            ttceb_pkg::CSR_TTC_LIMIT:   cfg_in.ttc_limit_ms  = csr_wdata[15:0];
            ttceb_pkg::CSR_HALF_WIDTH:  cfg_in.half_width_mm = csr_wdata[15:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_angle   <= 32'hA000_0000;
         cfg_ff.angle_step    <= 24'd2795203;
         cfg_ff.min_range_mm  <= 16'd0;
         cfg_ff.max_range_mm  <= 16'd30000;
         cfg_ff.ttc_limit_ms  <= 16'd500;
         cfg_ff.half_width_mm <= 16'd200;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ttceb_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req    (req),
      .cfg    (cfg_ff),
      .q_full (full),
      .q_push (push),
      .q_data (push_data)
   );

   ttceb_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .full      (full),
      .empty     (empty)
   );

   ttceb_back u_back (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .q_empty (empty),
      .q_data  (pop_data),
      .q_pop   (pop),
      .rsp     (rsp)
   );
endmodule

/* sv/ttceb_front.sv */
// Front end: accepts beams, counts the index, checks the range window, forms the angle.
// Depends on ttceb_pkg and ttceb_req_if.
module ttceb_front (
   input  logic                clock,
   input  logic                reset,
   ttceb_req_if.sink           req,
   input  ttceb_pkg::cfg_type  cfg,
   input  logic                q_full,
   output logic                q_push,
   output ttceb_pkg::beam_type q_data
);
   logic [ttceb_pkg::BEAM_W-1:0] count_ff, count_in;
   logic [31:0]                  offset;

   assign req.ready = !q_full;
   assign q_push    = req.valid && !q_full;
   assign offset    = 32'(count_ff) * 32'(cfg.angle_step);

   always_comb begin
      q_data.range_mm   = req.range_mm;
      q_data.speed_mm_s = req.speed_mm_s;
      q_data.scan_end   = req.scan_end;
      q_data.in_window  = req.range_ok && (req.range_mm <= cfg.max_range_mm)
                          && (req.range_mm >= cfg.min_range_mm);
      q_data.angle      = cfg.start_angle + offset;
      q_data.index      = count_ff;
      count_in          = count_ff;
      if (q_push) begin
         count_in = req.scan_end ? '0 : count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end
endmodule

/* sv/ttceb_queue.sv */
// Small FIFO of classified beams between the front end and the evaluation engine.
// Depends on ttceb_pkg.
module ttceb_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  ttceb_pkg::beam_type push_data,
   input  logic                pop,
   output ttceb_pkg::beam_type pop_data,
   output logic                full,
   output logic                empty
);
   ttceb_pkg::beam_type          mem [ttceb_pkg::QDEPTH];
   logic [ttceb_pkg::QPTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [ttceb_pkg::QPTR_W:0]   cnt_ff, cnt_in;

   assign full     = (cnt_ff == (ttceb_pkg::QPTR_W+1)'(ttceb_pkg::QDEPTH));
   assign empty    = (cnt_ff == '0);
   assign pop_data = mem[rd_ff];

   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (ttceb_pkg::QPTR_W+1)'(push) - (ttceb_pkg::QPTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end
endmodule

/* sv/ttceb_back.sv */
// Evaluation engine: iterative CORDIC, corridor and time-to-collision tests, scan verdict.
// Depends on ttceb_pkg and ttceb_rsp_if.
module ttceb_back (
   input  logic                clock,
   input  logic                reset,
   input  ttceb_pkg::cfg_type  cfg,
   input  logic                q_empty,
   input  ttceb_pkg::beam_type q_data,
   output logic                q_pop,
   ttceb_rsp_if.source         rsp
);
   localparam int CW = ttceb_pkg::CW;

   ttceb_pkg::back_state_type    st_ff, st_in;
   ttceb_pkg::beam_type          item_ff, item_in;
   logic signed [CW-1:0]         x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic [ttceb_pkg::ITER_W-1:0] iter_ff, iter_in;
   logic                         flip_ff, flip_in;
   logic signed [50:0]           lat_ff, lat_in;
   logic signed [49:0]           clos_ff, clos_in;
   logic [63:0]                  lhs_ff, lhs_in, rhs_ff, rhs_in;
   logic                         latched_ff, latched_in;
   logic [ttceb_pkg::BEAM_W-1:0] first_ff, first_in;
   logic                         rvalid_ff, rvalid_in, rbrake_ff, rbrake_in;
   logic [ttceb_pkg::HIT_W-1:0]  rhit_ff, rhit_in;

   logic [31:0]          fold;
   logic signed [CW-1:0] xs, ys, s_val, c_val;
   logic signed [50:0]   lat_abs;
   logic                 hit;

   assign rsp.valid    = rvalid_ff;
   assign rsp.brake    = rbrake_ff;
   assign rsp.hit_beam = rhit_ff;

   always_comb begin
      st_in      = st_ff;
      item_in    = item_ff;
      x_in       = x_ff;
      y_in       = y_ff;
      z_in       = z_ff;
      iter_in    = iter_ff;
      flip_in    = flip_ff;
      lat_in     = lat_ff;
      clos_in    = clos_ff;
      lhs_in     = lhs_ff;
      rhs_in     = rhs_ff;
      latched_in = latched_ff;
      first_in   = first_ff;
      rvalid_in  = rvalid_ff && !rsp.ready;
      rbrake_in  = rbrake_ff;
      rhit_in    = rhit_ff;
      q_pop      = 1'b0;
      fold       = q_data.angle;
      xs         = x_ff >>> iter_ff;
      ys         = y_ff >>> iter_ff;
      s_val      = flip_ff ? -y_ff : y_ff;
      c_val      = flip_ff ? -x_ff : x_ff;
      lat_abs    = (lat_ff < 0) ? -lat_ff : lat_ff;
      hit        = (lat_abs <= $signed(51'({cfg.half_width_mm, 30'b0})))
                   && (clos_ff > 0) && (lhs_ff < rhs_ff);

      unique case (st_ff)
         ttceb_pkg::ST_IDLE: begin
            if (!q_empty) begin
               q_pop   = 1'b1;
               item_in = q_data;
               flip_in = q_data.angle[31] ^ q_data.angle[30];
               if (flip_in) begin
                  fold = {~q_data.angle[31], q_data.angle[30:0]};
               end
               x_in    = ttceb_pkg::CORDIC_GAIN;
               y_in    = '0;
               z_in    = CW'($signed(fold));
               iter_in = '0;
               if (q_data.in_window && !latched_ff) begin
                  st_in = ttceb_pkg::ST_ROT;
               end else if (q_data.scan_end) begin
                  st_in = ttceb_pkg::ST_OUT;
               end
            end
         end
         ttceb_pkg::ST_ROT: begin
            if (!z_ff[CW-1]) begin
               x_in = x_ff - ys;
               y_in = y_ff + xs;
               z_in = z_ff - $signed(ttceb_pkg::atan_turn(iter_ff));
            end else begin
               x_in = x_ff + ys;
               y_in = y_ff - xs;
               z_in = z_ff + $signed(ttceb_pkg::atan_turn(iter_ff));
            end
            iter_in = iter_ff + 1'b1;
            if (iter_ff == ttceb_pkg::ITER_W'(ttceb_pkg::CORDIC_STEPS - 1)) begin
               st_in = ttceb_pkg::ST_MUL;
            end
         end
         ttceb_pkg::ST_MUL: begin
            lat_in  = 51'($signed({1'b0, item_ff.range_mm})) * 51'(s_val);
            clos_in = 50'(item_ff.speed_mm_s) * 50'(c_val);
            st_in   = ttceb_pkg::ST_MUL2;
         end
         ttceb_pkg::ST_MUL2: begin
            lhs_in = (64'(item_ff.range_mm) * 64'd1000) << 30;
            rhs_in = 64'(cfg.ttc_limit_ms) * 64'($unsigned(clos_ff));
            st_in  = ttceb_pkg::ST_CMP;
         end
         ttceb_pkg::ST_CMP: begin
            if (hit) begin
               latched_in = 1'b1;
               first_in   = item_ff.index;
            end
            st_in = item_ff.scan_end ? ttceb_pkg::ST_OUT : ttceb_pkg::ST_IDLE;
         end
         ttceb_pkg::ST_OUT: begin
            if (!rvalid_ff || rsp.ready) begin
               rvalid_in  = 1'b1;
               rbrake_in  = latched_ff;
               rhit_in    = latched_ff ? ttceb_pkg::HIT_W'(first_ff) : '0;
               latched_in = 1'b0;
               first_in   = '0;
               st_in      = ttceb_pkg::ST_IDLE;
            end
         end
         default: st_in = ttceb_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      iter_ff <= iter_in;
      flip_ff <= flip_in;
      lat_ff  <= lat_in;
      clos_ff <= clos_in;
      lhs_ff  <= lhs_in;
      rhs_ff  <= rhs_in;
      rbrake_ff <= rbrake_in;
      rhit_ff   <= rhit_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff      <= ttceb_pkg::ST_IDLE;
         latched_ff <= 1'b0;
         first_ff   <= '0;
         rvalid_ff  <= 1'b0;
      end else begin
         st_ff      <= st_in;
         latched_ff <= latched_in;
         first_ff   <= first_in;
         rvalid_ff  <= rvalid_in;
      end
   end
endmodule

/* tb/tb_top.sv */
// Self-checking testbench for the time-to-collision emergency brake block.
// Depends on ttceb_pkg, ttceb_req_if, ttceb_rsp_if and ttc_emergency_brake_top.
module tb_top;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [31:0] csr_wdata = '0;

   ttceb_req_if req ();
   ttceb_rsp_if rsp ();

   ttc_emergency_brake_top uut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #3000000;
      $display("status: fail");
      $finish;
   end

   typedef struct {
      logic        brake;
      logic [10:0] hit;
   } verdict_type;

   typedef struct {
      logic [15:0]        range_mm;
      logic               ok;
      logic signed [15:0] speed;
      logic               last;
      bit                 typed;
      logic               brake;
      logic [10:0]        hit;
   } beam_row_type;

   // Mirror of the configuration registers and the scan state.
   logic [31:0] m_start;
   logic [23:0] m_step;
   logic [15:0] m_min, m_max, m_ttc, m_half;
   logic [10:0] m_count, m_first;
   logic        m_latched;

   verdict_type verdict_q[$];
   int          errors = 0;
   int          long_hold = 0;
   bit          no_idle = 0;

   localparam longint GAIN_Q30 = 64'd652032874;
   localparam longint ATAN_TBL[24] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772,
      166886, 83443, 41722, 20861, 10430, 5215,
      2608, 1304, 652, 326, 163, 81
   };

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 60) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Rotation CORDIC with half-turn folding; shifts floor on signed values.
   function automatic void rotate(input logic [31:0] ang, output longint s,
                                  output longint c);
      longint x, y, z, nx;
      bit     flip;
      x = GAIN_Q30;
      y = 0;
      flip = (ang[31:30] == 2'd1) || (ang[31:30] == 2'd2);
      if (flip) ang = ang + 32'h8000_0000;
      z = longint'($signed(ang));
      for (int i = 0; i < ttceb_pkg::CORDIC_STEPS && i < 24; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i);
            y  = y + (x >>> i);
            z  = z - ATAN_TBL[i];
         end else begin
            nx = x + (y >>> i);
            y  = y - (x >>> i);
            z  = z + ATAN_TBL[i];
         end
         x = nx;
      end
      if (flip) begin
         x = -x;
         y = -y;
      end
      s = y;
      c = x;
   endfunction

   function automatic bit demands_brake(logic [15:0] rng, logic signed [15:0] spd,
                                        logic [10:0] idx);
      logic [31:0]     ang;
      longint          s, c, lat, closing;
      longint unsigned lhs, rhs;
      ang = m_start + 32'(idx) * 32'(m_step);
      rotate(ang, s, c);
      lat = longint'(rng) * s;
      if (lat < 0) lat = -lat;
      if (lat > (longint'(m_half) <<< 30)) return 0;
      closing = longint'(spd) * c;
      if (closing <= 0) return 0;
      lhs = (longint'(rng) * 1000) << 30;
      rhs = longint'(m_ttc) * closing;
      return lhs < rhs;
   endfunction

   // Advances the scan state by one accepted beam; returns 1 with a verdict on scan_end.
   function automatic bit scan_step(beam_row_type b, output verdict_type v);
      if (!m_latched && b.ok && b.range_mm <= m_max && b.range_mm >= m_min) begin
         if (demands_brake(b.range_mm, b.speed, m_count)) begin
            m_latched = 1'b1;
            m_first   = m_count;
         end
      end
      if (b.last) begin
         v.brake = m_latched;
         v.hit   = m_latched ? m_first : 11'd0;
         m_count = '0;
         m_latched = 1'b0;
         m_first = '0;
         return 1;
      end
      m_count = m_count + 11'd1;
      return 0;
   endfunction

   task automatic send_beam(beam_row_type b);
      int          g;
      verdict_type v;
      g = gap_len();
      if (g > 0) begin
         req.valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req.range_mm   <= b.range_mm;
      req.range_ok   <= b.ok;
      req.speed_mm_s <= b.speed;
      req.scan_end   <= b.last;
      req.valid      <= 1'b1;
      do @(posedge clock); while (!req.ready);
      if (scan_step(b, v)) begin
         if (b.typed) begin
            // Hand-typed rows must agree with the predictor as well.
            if (v.brake !== b.brake || v.hit !== b.hit) begin
               $error("typed row disagrees with predictor: brake %0b/%0b hit %0d/%0d",
                      b.brake, v.brake, b.hit, v.hit);
               errors++;
            end
            v.brake = b.brake;
            v.hit   = b.hit;
         end
         verdict_q.push_back(v);
      end
   endtask

   // Lets the block drain completely so registers can be changed safely.
   task automatic drain();
      req.valid <= 1'b0;
      @(posedge clock);
      while (verdict_q.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic csr_write(logic [2:0] idx, logic [31:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         ttceb_pkg::CSR_START_ANGLE: m_start = data;
         ttceb_pkg::CSR_ANGLE_STEP:  m_step  = data[23:0];
         ttceb_pkg::CSR_MIN_RANGE:   m_min   = data[15:0];
         ttceb_pkg::CSR_MAX_RANGE:   m_max   = data[15:0];
         ttceb_pkg::CSR_TTC_LIMIT:   m_ttc   = data[15:0];
         ttceb_pkg::CSR_HALF_WIDTH:  m_half  = data[15:0];
         default: ;
      endcase
   endtask

   task automatic set_config(logic [31:0] sa, logic [23:0] st, logic [15:0] mn,
                             logic [15:0] mx, logic [15:0] tl, logic [15:0] hw);
      drain();
      csr_write(ttceb_pkg::CSR_START_ANGLE, sa);
      csr_write(ttceb_pkg::CSR_ANGLE_STEP, {8'd0, st});
      csr_write(ttceb_pkg::CSR_MIN_RANGE, {16'd0, mn});
      csr_write(ttceb_pkg::CSR_MAX_RANGE, {16'd0, mx});
      csr_write(ttceb_pkg::CSR_TTC_LIMIT, {16'd0, tl});
      csr_write(ttceb_pkg::CSR_HALF_WIDTH, {16'd0, hw});
   endtask

   function automatic beam_row_type rand_beam(bit last);
      beam_row_type b;
      b.range_mm = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 3000))
                                               : 16'($urandom);
      b.ok       = ($urandom_range(0, 9) != 0);
      b.speed    = ($urandom_range(0, 9) < 7) ? 16'($urandom_range(0, 32767))
                                              : 16'($urandom);
      b.last     = last;
      b.typed    = 0;
      b.brake    = 0;
      b.hit      = 0;
      return b;
   endfunction

   task automatic random_scans(int n_items);
      int sent, len;
      sent = 0;
      while (sent < n_items) begin
         len = ($urandom_range(0, 19) == 0) ? $urandom_range(30, 60)
                                            : $urandom_range(1, 12);
         for (int k = 0; k < len; k++) send_beam(rand_beam(k == len - 1));
         sent += len;
      end
   endtask

   // Result side: random back-pressure plus an optional long hold-off, then checking.
   int rsp_stall = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp.valid && rsp.ready) begin
            if (verdict_q.size() == 0) begin
               $error("unexpected result transaction: brake %0b hit_beam %0d",
                      rsp.brake, rsp.hit_beam);
               errors++;
            end else begin
               verdict_type v;
               v = verdict_q.pop_front();
               if (rsp.brake !== v.brake) begin
                  $error("brake: expected %0b actual %0b", v.brake, rsp.brake);
                  errors++;
               end
               if (rsp.hit_beam !== v.hit) begin
                  $error("hit_beam: expected %0d actual %0d", v.hit, rsp.hit_beam);
                  errors++;
               end
            end
         end
         if (long_hold > 0) begin
            rsp.ready <= 1'b0;
            long_hold--;
         end else if (rsp_stall > 0) begin
            rsp.ready <= 1'b0;
            rsp_stall--;
         end else begin
            rsp.ready <= 1'b1;
            rsp_stall = gap_len();
         end
      end
   end

   beam_row_type directed[] = '{
      // NaN beam alone: never counts.
      '{16'd1000, 1'b0, 16'sd20000, 1'b1, 1, 1'b0, 11'd0},
      // Zero speed: no closing, no braking.
      '{16'd10, 1'b1, 16'sd0, 1'b1, 1, 1'b0, 11'd0},
      // Range extremes and speed extremes.
      '{16'd65535, 1'b1, 16'sd32767, 1'b1, 0, 1'b0, 11'd0},
      '{16'd0, 1'b1, -16'sd32768, 1'b1, 0, 1'b0, 11'd0},
      '{16'd0, 1'b1, 16'sd32767, 1'b1, 0, 1'b0, 11'd0},
      '{16'd30000, 1'b1, 16'sd32767, 1'b1, 0, 1'b0, 11'd0},
      '{16'd30001, 1'b1, 16'sd32767, 1'b1, 0, 1'b0, 11'd0},
      // Negative closing speed.
      '{16'd50, 1'b1, -16'sd1000, 1'b1, 0, 1'b0, 11'd0},
      // A multi-beam scan, with beams after a possible hit.
      '{16'd100, 1'b1, 16'sd30000, 1'b0, 0, 1'b0, 11'd0},
      '{16'd100, 1'b0, 16'sd30000, 1'b0, 0, 1'b0, 11'd0},
      '{16'd20, 1'b1, 16'sd30000, 1'b0, 0, 1'b0, 11'd0},
      '{16'd5, 1'b1, 16'sd32767, 1'b0, 0, 1'b0, 11'd0},
      '{16'd5, 1'b1, 16'sd32767, 1'b0, 0, 1'b0, 11'd0},
      '{16'd40000, 1'b1, -16'sd1, 1'b1, 0, 1'b0, 11'd0},
      '{16'd1, 1'b1, 16'sd1, 1'b0, 0, 1'b0, 11'd0},
      '{16'd65535, 1'b0, -16'sd32768, 1'b0, 0, 1'b0, 11'd0},
      '{16'd2, 1'b1, 16'sd16000, 1'b1, 0, 1'b0, 11'd0}
   };

   initial begin
      req.valid = 1'b0;
      req.range_mm = '0;
      req.range_ok = 1'b0;
      req.speed_mm_s = '0;
      req.scan_end = 1'b0;
      rsp.ready = 1'b0;
      m_start = 32'hA000_0000;
      m_step = 24'd2795203;
      m_min = 16'd0;
      m_max = 16'd30000;
      m_ttc = 16'd500;
      m_half = 16'd200;
      m_count = '0;
      m_latched = 1'b0;
      m_first = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table under the reset configuration, then under a corridor that brakes easily.
      foreach (directed[i]) send_beam(directed[i]);
      drain();
      // Out-of-list register indexes must be ignored.
      csr_write(3'd6, $urandom);
      csr_write(3'd7, $urandom);
      set_config(32'd0, 24'd1000, 16'd0, 16'd65535, 16'd65535, 16'd65535);
      foreach (directed[i]) send_beam(directed[i]);

      // Receiver holds off while the sender streams short scans, filling the queue.
      drain();
      long_hold = 400;
      no_idle = 1;
      for (int k = 0; k < 60; k++) send_beam(rand_beam($urandom_range(0, 1)));
      send_beam(rand_beam(1));
      no_idle = 0;

      // Random phases over extreme and random settings.
      set_config(32'h8000_0000, 24'hFF_FFFF, 16'd0, 16'd65535, 16'd65535, 16'd65535);
      random_scans(150);
      set_config(32'h7FFF_FFFF, 24'd0, 16'd0, 16'd65535, 16'd0, 16'd65535);
      random_scans(100);
      set_config(32'd0, 24'd100, 16'd40000, 16'd100, 16'd65535, 16'd65535);
      random_scans(100);
      set_config(32'd0, 24'd0, 16'd0, 16'd65535, 16'd65535, 16'd0);
      random_scans(100);
      for (int p = 0; p < 4; p++) begin
         set_config(($urandom & 32'h1FFF_FFFF) - 32'h1000_0000,
                    24'($urandom_range(0, 2000000)), 16'($urandom_range(0, 200)),
                    16'($urandom_range(2000, 65535)), 16'($urandom_range(100, 65535)),
                    16'($urandom_range(50, 65535)));
         no_idle = (p == 1);
         random_scans(150);
      end
      no_idle = 0;
      for (int p = 0; p < 2; p++) begin
         set_config($urandom, 24'($urandom), 16'($urandom), 16'($urandom),
                    16'($urandom), 16'($urandom));
         random_scans(100);
      end

      drain();
      if (errors == 0 && verdict_q.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

/* sim.f */
sv/ttceb_pkg.sv
sv/ttceb_req_if.sv
sv/ttceb_rsp_if.sv
sv/ttceb_front.sv
sv/ttceb_queue.sv
sv/ttceb_back.sv
sv/ttc_emergency_brake_top.sv
tb/tb_top.sv
